@@ rtl/size_string_parser_assert.svh @@
// ----------------------------------------------------------------------------
// size string parser assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef SIZE_STRING_PARSER_ASSERT_SVH
`define SIZE_STRING_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define SSP_ASSERT_IMPLY(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds
`define SSP_ASSERT_NEVER(label, c, r, cond, msg) \
    label: assert property (@(posedge c) disable iff (!r) !(cond)) \
        else $error(msg);

`else

`define SSP_ASSERT_IMPLY(label, c, r, ante, cons, msg)
`define SSP_ASSERT_NEVER(label, c, r, cond, msg)

`endif

`endif

@@ rtl/ssp_pkg.sv @@
// ----------------------------------------------------------------------------
// ssp_pkg
// types, character codes and helper functions of the size string parser
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

    localparam int CH_W       = 8;
    localparam int VAL_W      = 64;
    localparam int STAT_W     = 2;
    localparam int OUT_DATA_W = 72;
    localparam int KILO_SHIFT = 10;

    localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CH_W-1:0] CH_CR      = 8'h0d;
    localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS    = 8'h2b;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_ONE     = 8'h31;
    localparam logic [CH_W-1:0] CH_SEVEN   = 8'h37;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CH_W-1:0] CH_UPPER_G = 8'h47;
    localparam logic [CH_W-1:0] CH_UPPER_K = 8'h4b;
    localparam logic [CH_W-1:0] CH_UPPER_M = 8'h4d;
    localparam logic [CH_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CH_W-1:0] CH_LOWER_G = 8'h67;
    localparam logic [CH_W-1:0] CH_LOWER_K = 8'h6b;
    localparam logic [CH_W-1:0] CH_LOWER_M = 8'h6d;
    localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;

    // digit value 16 marks a character that is no hex digit
    localparam logic [4:0] DIGIT_NONE = 5'd16;
    localparam logic [4:0] LIM_OCT    = 5'd8;
    localparam logic [4:0] LIM_DEC    = 5'd10;
    localparam logic [4:0] LIM_HEX    = 5'd16;

    typedef enum logic [3:0] {
        PH_SPACE  = 4'd0,
        PH_SIGNED = 4'd1,
        PH_LEAD0  = 4'd2,
        PH_XSEEN  = 4'd3,
        PH_DIGITS = 4'd4,
        PH_GAP    = 4'd5,
        PH_NEG    = 4'd6,
        PH_DONE   = 4'd7
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_NONE = 2'd0,
        RADIX_OCT  = 2'd1,
        RADIX_DEC  = 2'd2,
        RADIX_HEX  = 2'd3
    } radix_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK  = 2'd0,
        ST_NEG = 2'd1,
        ST_OVF = 2'd2
    } status_t;

    typedef struct packed {
        logic [VAL_W-1:0] size_value;
        status_t          status;
    } result_t;

    function automatic logic [4:0] hex_value(input logic [CH_W-1:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 5'(c - CH_ZERO);
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            d = 5'(c - CH_LOWER_A + 8'd10);
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d = 5'(c - CH_UPPER_A + 8'd10);
        end
        return d;
    endfunction

    function automatic logic [1:0] suffix_count(input logic [CH_W-1:0] c);
        logic [1:0] n;
        n = 2'd0;
        if (c == CH_LOWER_K || c == CH_UPPER_K) begin
            n = 2'd1;
        end
        else if (c == CH_LOWER_M || c == CH_UPPER_M) begin
            n = 2'd2;
        end
        else if (c == CH_LOWER_G || c == CH_UPPER_G) begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

`default_nettype wire

@@ rtl/ssp_in_reg.sv @@
// ----------------------------------------------------------------------------
// ssp_in_reg
// input register holding one character transaction for the parser core
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_in_reg (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [ssp_pkg::CH_W-1:0] s_tdata,
    input  wire logic                     pop,
    output logic                          ch_vld,
    output logic [ssp_pkg::CH_W-1:0]      ch
);
    import ssp_pkg::*;

    logic            vld_reg;
    logic            vld_next;
    logic [CH_W-1:0] ch_reg;

    assign s_tready = !vld_reg || pop;
    assign ch_vld   = vld_reg;
    assign ch       = ch_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (s_tready) begin
            vld_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            ch_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ssp_core.sv @@
// ----------------------------------------------------------------------------
// ssp_core
// per-character parser state update and result formation at the string end
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_core (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step,
    input  wire logic [ssp_pkg::CH_W-1:0] ch,
    output logic                          res_load,
    output ssp_pkg::result_t              res
);
    import ssp_pkg::*;

    phase_t           phase_reg;
    phase_t           phase_next;
    radix_t           radix_reg;
    radix_t           radix_next;
    logic [VAL_W-1:0] accum_reg;
    logic [VAL_W-1:0] accum_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic [4:0]       digit;
    logic [4:0]       base_lim;
    logic [VAL_W+4:0] prod;
    logic [VAL_W+4:0] mac;
    logic             mac_ovf;
    logic [VAL_W-1:0] suffix_accum;
    logic [VAL_W-1:0] ch_low_digit;
    logic             is_nul;
    logic             is_dec_lead;
    logic             is_oct;
    logic             is_x;

    assign digit        = hex_value(ch);
    assign is_nul       = (ch == CH_NUL);
    assign is_dec_lead  = (ch >= CH_ONE) && (ch <= CH_NINE);
    assign is_oct       = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
    assign is_x         = (ch == CH_LOWER_X) || (ch == CH_UPPER_X);
    assign ch_low_digit = {{(VAL_W-5){1'b0}}, digit};

    always_comb
    begin
        unique case (radix_reg)
            RADIX_OCT: base_lim = LIM_OCT;
            RADIX_HEX: base_lim = LIM_HEX;
            default:   base_lim = LIM_DEC;
        endcase
    end

    // accum times base, plus digit, with carry bits kept for the overflow test
    always_comb
    begin
        unique case (radix_reg)
            RADIX_OCT: prod = {2'b00, accum_reg, 3'b000};
            RADIX_HEX: prod = {1'b0, accum_reg, 4'b0000};
            default:   prod = {2'b00, accum_reg, 3'b000} + {4'b0000, accum_reg, 1'b0};
        endcase
        mac     = prod + {{VAL_W{1'b0}}, digit};
        mac_ovf = |mac[VAL_W+4:VAL_W];
    end

    always_comb
    begin
        unique case (suffix_count(ch))
            2'd1:    suffix_accum = accum_reg << KILO_SHIFT;
            2'd2:    suffix_accum = accum_reg << (2 * KILO_SHIFT);
            2'd3:    suffix_accum = accum_reg << (3 * KILO_SHIFT);
            default: suffix_accum = accum_reg;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        accum_next = accum_reg;
        ovf_next   = ovf_reg;
        res_load   = 1'b0;
        res        = '{size_value: accum_reg, status: ST_OK};

        if (phase_reg == PH_NEG) begin
            res = '{size_value: '0, status: ST_NEG};
        end
        else if (ovf_reg) begin
            res = '{size_value: '0, status: ST_OVF};
        end

        if (step) begin
            if (is_nul) begin
                res_load   = 1'b1;
                phase_next = PH_SPACE;
                radix_next = RADIX_NONE;
                accum_next = '0;
                ovf_next   = 1'b0;
            end
            else begin
                unique case (phase_reg)
                    PH_SPACE, PH_SIGNED:
                    begin
                        priority if (phase_reg == PH_SPACE && is_space(ch)) begin
                            phase_next = PH_SPACE;
                        end
                        else if (phase_reg == PH_SPACE && ch == CH_MINUS) begin
                            phase_next = PH_NEG;
                        end
                        else if (phase_reg == PH_SPACE && ch == CH_PLUS) begin
                            phase_next = PH_SIGNED;
                        end
                        else if (ch == CH_ZERO) begin
                            accum_next = '0;
                            phase_next = PH_LEAD0;
                        end
                        else if (is_dec_lead) begin
                            radix_next = RADIX_DEC;
                            accum_next = ch_low_digit;
                            phase_next = PH_DIGITS;
                        end
                        else begin
                            accum_next = '0;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_LEAD0:
                    begin
                        priority if (is_x) begin
                            phase_next = PH_XSEEN;
                        end
                        else if (is_oct) begin
                            radix_next = RADIX_OCT;
                            accum_next = ch_low_digit;
                            phase_next = PH_DIGITS;
                        end
                        else if (ch == CH_SPACE) begin
                            phase_next = PH_GAP;
                        end
                        else begin
                            accum_next = suffix_accum;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_XSEEN:
                    begin
                        if (digit != DIGIT_NONE) begin
                            radix_next = RADIX_HEX;
                            accum_next = ch_low_digit;
                            phase_next = PH_DIGITS;
                        end
                        else begin
                            accum_next = '0;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DIGITS:
                    begin
                        priority if (digit < base_lim) begin
                            if (!ovf_reg) begin
                                if (mac_ovf) begin
                                    ovf_next   = 1'b1;
                                    accum_next = '0;
                                end
                                else begin
                                    accum_next = mac[VAL_W-1:0];
                                end
                            end
                        end
                        else if (ch == CH_SPACE) begin
                            phase_next = PH_GAP;
                        end
                        else begin
                            accum_next = suffix_accum;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_GAP:
                    begin
                        accum_next = suffix_accum;
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_SPACE;
            radix_reg <= RADIX_NONE;
            accum_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
            accum_reg <= accum_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ssp_out_reg.sv @@
// ----------------------------------------------------------------------------
// ssp_out_reg
// result register driving the master side of the stream
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_out_reg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire ssp_pkg::result_t               res,
    output logic                                free,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ssp_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import ssp_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign free     = !vld_reg || m_tready;
    assign m_tvalid = vld_reg;
    assign m_tdata  = {{(OUT_DATA_W-VAL_W-STAT_W){1'b0}}, res_reg.status, res_reg.size_value};

    always_comb
    begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end
        else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

@@ rtl/size_string_parser.sv @@
// ----------------------------------------------------------------------------
// size_string_parser
// parses a NUL-terminated size string with auto base and k/m/g suffix
//
//   channel  dir  tdata fields (lsb first)              transaction
//   s_*      in   ch[7:0]                               one character
//   m_*      out  size_value[63:0], status[65:64], 0s   one result per NUL
//
// one character per cycle while no NUL waits on a stalled result; a result
// is loaded when its NUL leaves the input register, through the parser state
// update into the result register
// rst_n clears the parser state, the input register and the result register
// a stalled result blocks only a following NUL; other characters keep flowing
// ----------------------------------------------------------------------------
`default_nettype none

`include "size_string_parser_assert.svh"

module size_string_parser (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [ssp_pkg::CH_W-1:0]  s_tdata,      // ch[7:0]
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [ssp_pkg::OUT_DATA_W-1:0] m_tdata       // size_value[63:0], status[65:64]
);
    import ssp_pkg::*;

    logic            ch_vld;
    logic [CH_W-1:0] ch;
    logic            pop;
    logic            out_free;
    logic            res_load;
    result_t         res;

    // a NUL may only move on once the result register can take its result
    assign pop = ch_vld && ((ch != CH_NUL) || out_free);

    ssp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .pop      (pop),
        .ch_vld   (ch_vld),
        .ch       (ch)
    );

    ssp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (pop),
        .ch       (ch),
        .res_load (res_load),
        .res      (res)
    );

    ssp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `SSP_ASSERT_IMPLY(a_load_into_free, clk, rst_n, res_load, out_free, "result loaded over a pending result")
    `SSP_ASSERT_IMPLY(a_stall_only_on_nul, clk, rst_n, !s_tready, ch_vld && ch == CH_NUL && m_tvalid && !m_tready, "input stalled without a blocked result")
    `SSP_ASSERT_NEVER(a_bad_status_value, clk, rst_n, m_tvalid && m_tdata[65:64] != ST_OK && m_tdata[63:0] != '0, "nonzero value with error status")

endmodule

`default_nettype wire
